>>> hw/rtl/msqd_pkg.sv
`default_nettype none

package msqd_pkg;

  // Build defaults
  localparam int MAX_SERVERS_DEF = 16;
  localparam int TIME_BITS_DEF   = 24;

  // Fixed field widths
  localparam int ARR_W   = 16;
  localparam int SVC_W   = 8;
  localparam int SVCC_W  = 6;
  localparam int NW_W    = 5;
  localparam int SIDX_W  = 4;
  localparam int WAIT_W  = 24;
  localparam int CNT_W   = 16;
  localparam int TOT_W   = 32;

  // Behavioral constants
  localparam int SERVICE_CAP = 60;
  localparam logic [WAIT_W-1:0] W24_MAX = '1;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch a new request, restart the scan
    logic scan;    // examine one server finish time
    logic commit;  // update server and statistics, load the result register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;  // free server found or last active server examined
  } sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/msqd_ctrl.sv
`default_nettype none

module msqd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire msqd_pkg::sts_t sts,
  output msqd_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_CNT  = 4'b0100,
    S_UPD  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_UPD) && (!out_valid || out_ready);
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SCAN;
      S_SCAN: if (sts.scan_done) state_next = S_CNT;
      S_CNT:  state_next = S_UPD;
      S_UPD:  if (cmd.commit) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result until taken; a commit refills it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_SCAN))
    else $error("accepted request did not start a scan");

  a_commit_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (out_valid && state == S_IDLE))
    else $error("commit did not present a result");

  a_single_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan, cmd.commit}))
    else $error("overlapping datapath commands");

endmodule

`default_nettype wire

>>> hw/rtl/msqd_dp.sv
`default_nettype none

module msqd_dp #(
  parameter int MAX_SERVERS = msqd_pkg::MAX_SERVERS_DEF,
  parameter int TIME_BITS   = msqd_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire msqd_pkg::cmd_t                cmd,
  output msqd_pkg::sts_t                     sts,
  input  wire logic                          cfg_wr,
  input  wire logic [msqd_pkg::NW_W-1:0]     cfg_data,
  input  wire logic [msqd_pkg::ARR_W-1:0]    arrival_time,
  input  wire logic [msqd_pkg::SVC_W-1:0]    service_time,
  output logic      [msqd_pkg::SIDX_W-1:0]   server_index,
  output logic      [msqd_pkg::WAIT_W-1:0]   wait_time,
  output logic      [msqd_pkg::CNT_W-1:0]    server_job_count,
  output logic      [msqd_pkg::WAIT_W-1:0]   max_wait_so_far,
  output logic      [msqd_pkg::TOT_W-1:0]    total_wait_so_far,
  output logic      [msqd_pkg::WAIT_W-1:0]   latest_finish
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int DEPTH = 1 << IDX_W;
  localparam int WX    = (TIME_BITS > msqd_pkg::WAIT_W) ? TIME_BITS : msqd_pkg::WAIT_W;
  localparam int T     = TIME_BITS;

  // Server stores
  logic [T-1:0]                  fin_mem [DEPTH];
  logic [msqd_pkg::CNT_W-1:0]    cnt_mem [DEPTH];
  logic [DEPTH-1:0]              entry_vld;
  logic [T-1:0]                  fin_rd;
  logic [msqd_pkg::CNT_W-1:0]    cnt_rd;
  logic [IDX_W-1:0]              rd_addr;

  // Request and scan registers
  logic [msqd_pkg::NW_W-1:0]     num_windows;
  logic [msqd_pkg::ARR_W-1:0]    arrival;
  logic [msqd_pkg::SVCC_W-1:0]   service;
  logic [IDX_W-1:0]              scan_idx;
  logic [IDX_W-1:0]              pick;
  logic [T-1:0]                  best;
  logic                          found;

  // Running statistics
  logic [msqd_pkg::WAIT_W-1:0]   max_wait;
  logic [msqd_pkg::TOT_W-1:0]    total_wait;
  logic [msqd_pkg::WAIT_W-1:0]   finish_peak;

  logic [IDX_W-1:0]              act_m1;
  logic [T-1:0]                  arr_ext;
  logic                          is_free;
  logic                          is_last;
  logic [T-1:0]                  start;
  logic [T:0]                    fin_sum;
  logic [T-1:0]                  fin_new;
  logic [T-1:0]                  wait_t;
  logic [WX-1:0]                 wait_x;
  logic [WX-1:0]                 fin_x;
  logic [msqd_pkg::WAIT_W-1:0]   wait24;
  logic [msqd_pkg::WAIT_W-1:0]   fin24;
  logic [msqd_pkg::CNT_W-1:0]    cnt_new;
  logic [msqd_pkg::TOT_W:0]      tot_sum;
  logic [msqd_pkg::TOT_W-1:0]    tot_new;
  logic [msqd_pkg::WAIT_W-1:0]   max_new;
  logic [msqd_pkg::WAIT_W-1:0]   peak_new;

  // Clamp the active server count to 1..MAX_SERVERS, kept as count minus one
  always_comb begin
    if (num_windows == '0) begin
      act_m1 = '0;
    end else if (int'(num_windows) > MAX_SERVERS) begin
      act_m1 = IDX_W'(MAX_SERVERS - 1);
    end else begin
      act_m1 = IDX_W'(num_windows - msqd_pkg::NW_W'(1));
    end
  end

  assign arr_ext  = T'(arrival);
  assign is_free  = (fin_rd <= arr_ext);
  assign is_last  = (scan_idx == act_m1);
  assign sts.scan_done = cmd.scan && (is_free || is_last);
  assign rd_addr  = cmd.scan ? scan_idx + IDX_W'(1) : '0;

  assign start    = found ? arr_ext : best;
  assign fin_sum  = {1'b0, start} + (T+1)'(service);
  assign fin_new  = fin_sum[T] ? '1 : fin_sum[T-1:0];
  assign wait_t   = found ? '0 : best - arr_ext;
  assign wait_x   = WX'(wait_t);
  assign fin_x    = WX'(fin_new);
  assign wait24   = (wait_x > WX'(msqd_pkg::W24_MAX)) ? msqd_pkg::W24_MAX
                                                     : wait_x[msqd_pkg::WAIT_W-1:0];
  assign fin24    = (fin_x > WX'(msqd_pkg::W24_MAX)) ? msqd_pkg::W24_MAX
                                                    : fin_x[msqd_pkg::WAIT_W-1:0];
  assign cnt_new  = (cnt_rd == '1) ? cnt_rd : cnt_rd + msqd_pkg::CNT_W'(1);
  assign tot_sum  = {1'b0, total_wait} + (msqd_pkg::TOT_W+1)'(wait_t);
  assign tot_new  = tot_sum[msqd_pkg::TOT_W] ? '1 : tot_sum[msqd_pkg::TOT_W-1:0];
  assign max_new  = (wait24 > max_wait) ? wait24 : max_wait;
  assign peak_new = (fin24 > finish_peak) ? fin24 : finish_peak;

  // Stores: one write and one registered read each; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      fin_mem[pick] <= fin_new;
      cnt_mem[pick] <= cnt_new;
    end
    fin_rd <= entry_vld[rd_addr] ? fin_mem[rd_addr] : '0;
    cnt_rd <= entry_vld[pick] ? cnt_mem[pick] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (cmd.commit) begin
      entry_vld[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_windows <= msqd_pkg::NW_W'(1);
    end else if (cfg_wr) begin
      num_windows <= cfg_data;
    end
  end

  // Request latch and scan
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arrival  <= arrival_time;
      service  <= (service_time > msqd_pkg::SVC_W'(msqd_pkg::SERVICE_CAP))
                  ? msqd_pkg::SVCC_W'(msqd_pkg::SERVICE_CAP)
                  : service_time[msqd_pkg::SVCC_W-1:0];
      scan_idx <= '0;
      pick     <= '0;
      found    <= 1'b0;
    end else if (cmd.scan) begin
      scan_idx <= scan_idx + IDX_W'(1);
      if (is_free) begin
        pick  <= scan_idx;
        found <= 1'b1;
      end else if (scan_idx == '0 || fin_rd < best) begin
        pick <= scan_idx;
        best <= fin_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait    <= '0;
      total_wait  <= '0;
      finish_peak <= '0;
    end else if (cmd.commit) begin
      max_wait    <= max_new;
      total_wait  <= tot_new;
      finish_peak <= peak_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      server_index      <= msqd_pkg::SIDX_W'(pick);
      wait_time         <= wait24;
      server_job_count  <= cnt_new;
      max_wait_so_far   <= max_new;
      total_wait_so_far <= tot_new;
      latest_finish     <= peak_new;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/multi_server_queue_dispatcher.sv
// Operation: an accepted request scans N servers, N being the
//   number of servers examined (1 up to the active count; a free server stops the scan).
// Flow: the scan reads one server finish time per cycle through the single read port of
//   the finish store; a new request is taken only after the last one has committed.
// Reset: synchronous, active high; clears all server stores (valid bits), the
//   statistics and the result handshake, and sets the active server count to 1.
`default_nettype none

module multi_server_queue_dispatcher #(
  parameter int MAX_SERVERS = msqd_pkg::MAX_SERVERS_DEF,
  parameter int TIME_BITS   = msqd_pkg::TIME_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write: active server count
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [msqd_pkg::NW_W-1:0]     cfg_data,
  // Request channel: one job per request
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [msqd_pkg::ARR_W-1:0]    arrival_time,
  input  wire logic [msqd_pkg::SVC_W-1:0]    service_time,
  // Result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [msqd_pkg::SIDX_W-1:0]   server_index,
  output logic      [msqd_pkg::WAIT_W-1:0]   wait_time,
  output logic      [msqd_pkg::CNT_W-1:0]    server_job_count,
  output logic      [msqd_pkg::WAIT_W-1:0]   max_wait_so_far,
  output logic      [msqd_pkg::TOT_W-1:0]    total_wait_so_far,
  output logic      [msqd_pkg::WAIT_W-1:0]   latest_finish
);

  msqd_pkg::cmd_t cmd;
  msqd_pkg::sts_t sts;

  // The count register takes a write in any cycle
  assign cfg_ready = 1'b1;

  // Controller: idle, scan the servers, fetch the chosen server's count,
  // then commit once the result register is free. A new request is taken in
  // idle while the previous result still waits at the output.
  msqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: server stores, scan compare, saturating statistics and the
  // result register.
  msqd_dp #(
    .MAX_SERVERS (MAX_SERVERS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_wr            (cfg_valid && cfg_ready),
    .cfg_data          (cfg_data),
    .arrival_time      (arrival_time),
    .service_time      (service_time),
    .server_index      (server_index),
    .wait_time         (wait_time),
    .server_job_count  (server_job_count),
    .max_wait_so_far   (max_wait_so_far),
    .total_wait_so_far (total_wait_so_far),
    .latest_finish     (latest_finish)
  );

endmodule

`default_nettype wire
